/* design/tccw_pkg.sv */
// Shared constants, types and codes for the text console cell writer.
package tccw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam int READ_CELL_W   = 11;
  localparam int CURSOR_CELL_W = 11;
  localparam int CHAR_W        = 8;
  localparam int COLOR_W       = 4;
  localparam int ATTR_W        = 8;
  localparam int CELL_W        = CHAR_W + ATTR_W;
  localparam int TAB_WIDTH_W   = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 8;

  localparam logic [CHAR_W-1:0] CHAR_NUL       = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB       = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;

  localparam logic [TAB_WIDTH_W-1:0] TAB_WIDTH_RST  = 4'd4;
  localparam logic [ATTR_W-1:0]      TAB_ATTR_RST   = 8'd15;
  localparam logic [ATTR_W-1:0]      BLANK_ATTR_RST = 8'd0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TAB_WIDTH  = 2'd0,
    CFG_TAB_ATTR   = 2'd1,
    CFG_BLANK_ATTR = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [TAB_WIDTH_W-1:0] tab_width;
    logic [ATTR_W-1:0]      tab_attr;
    logic [ATTR_W-1:0]      blank_attr;
  } cfg_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_INC,
    CUR_DEC,
    CUR_NEWLINE,
    CUR_ZERO
  } cur_op_e;

  typedef struct packed {
    logic at_end;
    logic at_last;
    logic at_zero;
    logic col_zero;
  } cur_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_DATA,
    ST_CHECK,
    ST_TAB,
    ST_CLEAR,
    ST_BS_RD,
    ST_BS_CMP,
    ST_FINISH
  } state_e;

endpackage

/* design/tccw_if.sv */
// Valid/ready channel interfaces for input items, results and register writes.
interface tccw_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 kind;
  logic [tccw_pkg::CHAR_W-1:0]          char_code;
  logic [tccw_pkg::COLOR_W-1:0]         fg_color;
  logic [tccw_pkg::COLOR_W-1:0]         bg_color;
  logic [tccw_pkg::READ_CELL_W-1:0]     read_cell;

  modport source (output valid, kind, char_code, fg_color, bg_color, read_cell, input ready);
  modport sink   (input valid, kind, char_code, fg_color, bg_color, read_cell, output ready);
endinterface

interface tccw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [tccw_pkg::CURSOR_CELL_W-1:0]   cursor_cell;
  logic                                 screen_cleared;
  logic [tccw_pkg::CHAR_W-1:0]          read_char;
  logic [tccw_pkg::ATTR_W-1:0]          read_attr;

  modport source (output valid, cursor_cell, screen_cleared, read_char, read_attr, input ready);
  modport sink   (input valid, cursor_cell, screen_cleared, read_char, read_attr, output ready);
endinterface

interface tccw_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tccw_pkg::CFG_INDEX_W-1:0]     index;
  logic [tccw_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/tccw_cursor.sv */
// Cursor unit: one shared adder steps, rewinds and moves the cursor to the next row; a select zeroes it.
module tccw_cursor #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  tccw_pkg::cur_op_e                      op_i,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]      cursor_o,
  output logic [$clog2(COLUMNS*ROWS+1)-1:0]      prev_o,
  output tccw_pkg::cur_status_t                  status_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CUR_W = $clog2(CELLS + 1);
  localparam int COL_W = $clog2(COLUMNS);

  logic [CUR_W-1:0] cursor_q, cursor_d, delta;
  logic [COL_W-1:0] col_q, col_d;

  always_comb begin
    delta = '0;
    col_d = col_q;
    unique case (op_i)
      tccw_pkg::CUR_HOLD: begin
        delta = '0;
      end
      tccw_pkg::CUR_INC: begin
        delta = CUR_W'(1);
        col_d = (col_q == COL_W'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
      end
      tccw_pkg::CUR_DEC: begin
        delta = '1;
        col_d = (col_q == '0) ? COL_W'(COLUMNS - 1) : col_q - 1'b1;
      end
      tccw_pkg::CUR_NEWLINE: begin
        // jump to the start of the next row
        delta = CUR_W'(COLUMNS) - CUR_W'(col_q);
        col_d = '0;
      end
      tccw_pkg::CUR_ZERO: begin
        col_d = '0;
      end
      default: begin
        delta = '0;
      end
    endcase
    cursor_d = (op_i == tccw_pkg::CUR_ZERO) ? '0 : cursor_q + delta;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      col_q    <= '0;
    end else begin
      cursor_q <= cursor_d;
      col_q    <= col_d;
    end
  end

  assign cursor_o          = cursor_q;
  assign prev_o            = cursor_q - 1'b1;
  assign status_o.at_end   = (cursor_q >= CUR_W'(CELLS));
  assign status_o.at_last  = (cursor_q == CUR_W'(CELLS - 1));
  assign status_o.at_zero  = (cursor_q == '0);
  assign status_o.col_zero = (col_q == '0);

  a_cursor_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= CUR_W'(CELLS))
    else $error("cursor beyond end of screen");

  a_zero_is_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_q == '0) |-> (col_q == '0))
    else $error("column count out of step with cursor");

endmodule

/* design/tccw_mem.sv */
// Screen cell memory: one write port and one registered read port.
module tccw_mem #(
  parameter int DEPTH = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DEPTH)-1:0]      waddr_i,
  input  logic [tccw_pkg::CELL_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DEPTH)-1:0]      raddr_i,
  output logic [tccw_pkg::CELL_W-1:0]   rdata_o
);

  logic [tccw_pkg::CELL_W-1:0] mem_q [DEPTH];
  logic [tccw_pkg::CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tccw_ctrl.sv */
// Sequencer: decodes items, drives the cursor unit and the cell memory, holds the result.
module tccw_ctrl #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  tccw_in_if.sink                                   in_i,
  tccw_out_if.source                                out_o,
  input  tccw_pkg::cfg_t                            cfg_i,
  input  logic [$clog2(COLUMNS*ROWS+1)-1:0]         cursor_i,
  input  logic [$clog2(COLUMNS*ROWS+1)-1:0]         prev_i,
  input  tccw_pkg::cur_status_t                     status_i,
  output tccw_pkg::cur_op_e                         cur_op_o,
  output logic                                      mem_we_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_waddr_o,
  output logic [tccw_pkg::CELL_W-1:0]               mem_wdata_o,
  output logic                                      mem_re_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]           mem_raddr_o,
  input  logic [tccw_pkg::CELL_W-1:0]               mem_rdata_i
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int WIDE_W = (tccw_pkg::READ_CELL_W > CUR_W) ? tccw_pkg::READ_CELL_W : CUR_W;

  tccw_pkg::state_e state_q, state_d;

  logic                                 out_valid_q;
  logic [tccw_pkg::CURSOR_CELL_W-1:0]   out_cursor_q;
  logic                                 out_cleared_q;
  logic [tccw_pkg::CHAR_W-1:0]          out_char_q;
  logic [tccw_pkg::ATTR_W-1:0]          out_attr_q;

  logic [tccw_pkg::TAB_WIDTH_W-1:0]     tab_cnt_q;
  logic                                 walk_q;
  logic                                 cleared_q;
  logic                                 rd_hit_q;
  logic [tccw_pkg::CHAR_W-1:0]          target_q;
  logic [tccw_pkg::CHAR_W-1:0]          res_char_q;
  logic [tccw_pkg::ATTR_W-1:0]          res_attr_q;

  logic                                 accept;
  logic                                 out_free;
  logic [WIDE_W-1:0]                    rc_wide;
  logic                                 rc_hit;
  logic [tccw_pkg::CHAR_W-1:0]          rd_char;
  logic                                 bs_first_blank;
  logic                                 bs_walk_more;

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign rc_wide  = WIDE_W'(in_i.read_cell);
  assign rc_hit   = (rc_wide < WIDE_W'(CELLS));
  assign rd_char  = mem_rdata_i[tccw_pkg::CHAR_W-1:0];

  // first backspace step: row start with a blank before it
  assign bs_first_blank = status_i.col_zero && (rd_char == tccw_pkg::CHAR_BLANK);
  assign bs_walk_more   = walk_q ? (rd_char == target_q)
                                 : (bs_first_blank || (rd_char == tccw_pkg::CHAR_NUL));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tccw_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.kind) begin
            state_d = tccw_pkg::ST_RD_DATA;
          end else if (in_i.char_code == tccw_pkg::CHAR_BACKSPACE) begin
            state_d = tccw_pkg::ST_BS_RD;
          end else begin
            state_d = tccw_pkg::ST_CHECK;
          end
        end
      end
      tccw_pkg::ST_RD_DATA: state_d = tccw_pkg::ST_FINISH;
      tccw_pkg::ST_CHECK: begin
        priority if (status_i.at_end) begin
          state_d = tccw_pkg::ST_CLEAR;
        end else if (tab_cnt_q != '0) begin
          state_d = tccw_pkg::ST_TAB;
        end else begin
          state_d = tccw_pkg::ST_FINISH;
        end
      end
      tccw_pkg::ST_TAB: state_d = tccw_pkg::ST_CHECK;
      tccw_pkg::ST_CLEAR: begin
        if (status_i.at_last) begin
          state_d = tccw_pkg::ST_CHECK;
        end
      end
      tccw_pkg::ST_BS_RD: begin
        state_d = status_i.at_zero ? tccw_pkg::ST_CHECK : tccw_pkg::ST_BS_CMP;
      end
      tccw_pkg::ST_BS_CMP: begin
        state_d = bs_walk_more ? tccw_pkg::ST_BS_RD : tccw_pkg::ST_CHECK;
      end
      tccw_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = tccw_pkg::ST_IDLE;
        end
      end
      default: state_d = tccw_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_i.ready  = 1'b0;
    cur_op_o    = tccw_pkg::CUR_HOLD;
    mem_we_o    = 1'b0;
    mem_waddr_o = ADDR_W'(cursor_i);
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = ADDR_W'(prev_i);
    unique case (state_q)
      tccw_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (in_i.kind) begin
            mem_re_o    = rc_hit;
            mem_raddr_o = ADDR_W'(rc_wide);
          end else begin
            unique case (in_i.char_code)
              tccw_pkg::CHAR_NEWLINE:   cur_op_o = tccw_pkg::CUR_NEWLINE;
              tccw_pkg::CHAR_BACKSPACE: cur_op_o = tccw_pkg::CUR_HOLD;
              tccw_pkg::CHAR_TAB:       cur_op_o = tccw_pkg::CUR_HOLD;
              default: begin
                mem_we_o    = 1'b1;
                mem_wdata_o = {in_i.bg_color, in_i.fg_color, in_i.char_code};
                cur_op_o    = tccw_pkg::CUR_INC;
              end
            endcase
          end
        end
      end
      tccw_pkg::ST_RD_DATA: begin
        cur_op_o = tccw_pkg::CUR_HOLD;
      end
      tccw_pkg::ST_CHECK: begin
        if (status_i.at_end) begin
          cur_op_o = tccw_pkg::CUR_ZERO;
        end
      end
      tccw_pkg::ST_TAB: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {cfg_i.tab_attr, tccw_pkg::CHAR_NUL};
        cur_op_o    = tccw_pkg::CUR_INC;
      end
      tccw_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = {cfg_i.blank_attr, tccw_pkg::CHAR_BLANK};
        cur_op_o    = status_i.at_last ? tccw_pkg::CUR_ZERO : tccw_pkg::CUR_INC;
      end
      tccw_pkg::ST_BS_RD: begin
        mem_re_o = !status_i.at_zero;
      end
      tccw_pkg::ST_BS_CMP: begin
        if (!walk_q && !bs_walk_more) begin
          // plain backspace: blank the previous cell
          mem_we_o    = 1'b1;
          mem_waddr_o = ADDR_W'(prev_i);
          mem_wdata_o = {cfg_i.blank_attr, tccw_pkg::CHAR_BLANK};
        end
        if (!walk_q || bs_walk_more) begin
          cur_op_o = tccw_pkg::CUR_DEC;
        end
      end
      tccw_pkg::ST_FINISH: begin
        cur_op_o = tccw_pkg::CUR_HOLD;
      end
      default: begin
        cur_op_o = tccw_pkg::CUR_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tccw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      tab_cnt_q   <= '0;
      walk_q      <= 1'b0;
      cleared_q   <= 1'b0;
      rd_hit_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tccw_pkg::ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        rd_hit_q  <= in_i.kind && rc_hit;
        cleared_q <= 1'b0;
        walk_q    <= 1'b0;
        tab_cnt_q <= (!in_i.kind && in_i.char_code == tccw_pkg::CHAR_TAB) ?
                     cfg_i.tab_width : '0;
      end
      if (state_q == tccw_pkg::ST_TAB) begin
        tab_cnt_q <= tab_cnt_q - 1'b1;
      end
      if (state_q == tccw_pkg::ST_CHECK && status_i.at_end) begin
        cleared_q <= 1'b1;
      end
      if (state_q == tccw_pkg::ST_BS_CMP) begin
        walk_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_char_q <= '0;
      res_attr_q <= '0;
    end
    if (state_q == tccw_pkg::ST_RD_DATA && rd_hit_q) begin
      res_char_q <= mem_rdata_i[tccw_pkg::CHAR_W-1:0];
      res_attr_q <= mem_rdata_i[tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
    end
    if (state_q == tccw_pkg::ST_BS_CMP && !walk_q) begin
      target_q <= bs_first_blank ? tccw_pkg::CHAR_BLANK : tccw_pkg::CHAR_NUL;
    end
    if (state_q == tccw_pkg::ST_FINISH && out_free) begin
      out_cursor_q  <= tccw_pkg::CURSOR_CELL_W'(cursor_i);
      out_cleared_q <= cleared_q;
      out_char_q    <= res_char_q;
      out_attr_q    <= res_attr_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.cursor_cell    = out_cursor_q;
  assign out_o.screen_cleared = out_cleared_q;
  assign out_o.read_char      = out_char_q;
  assign out_o.read_attr      = out_attr_q;

  a_idle_below_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_IDLE) |-> !status_i.at_end)
    else $error("idle with cursor at end of screen");

  a_idle_no_tab_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tccw_pkg::ST_IDLE) |-> (tab_cnt_q == '0))
    else $error("tab cells left over after item");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o && (mem_waddr_o == mem_raddr_o)))
    else $error("read and write of the same cell in one cycle");

  a_cleared_from_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cleared_q) |-> ($past(state_q) == tccw_pkg::ST_CHECK))
    else $error("clear flag set outside end check");

endmodule

/* design/text_console_cell_writer_top.sv */
// Top level of the text console cell writer: registers, cursor unit, cell memory, sequencer.
//
//  channel  dir  handshake        payload
//  in_i     in   valid / ready    kind, char_code, fg_color, bg_color, read_cell
//  out_o    out  valid / ready    cursor_cell, screen_cleared, read_char, read_attr
//  cfg_i    in   valid / ready    index, data (ready always high)
//
//  Read item: the read is issued on accept, ST_RD_DATA takes the data, ST_FINISH loads the result.
//  Printable or newline: ST_CHECK, then ST_FINISH. Tab: ST_CHECK and ST_TAB per tab cell, then ST_CHECK, ST_FINISH.
//  Backspace: ST_BS_RD and ST_BS_CMP per cell examined, then ST_CHECK and ST_FINISH.
//  A wrap runs ST_CLEAR, which writes one cell a cycle through the single memory
//  write port. No clearing pass after reset; cells are unknown until written.
//  One result is held in the output register; a finished item waits there while out_o stalls.
module text_console_cell_writer_top #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tccw_in_if.sink    in_i,
  tccw_out_if.source out_o,
  tccw_cfg_if.sink   cfg_i
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int CUR_W  = $clog2(CELLS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  tccw_pkg::cfg_t        cfg_q;
  tccw_pkg::cur_op_e     cur_op;
  tccw_pkg::cur_status_t cur_status;
  logic [CUR_W-1:0]      cursor;
  logic [CUR_W-1:0]      prev;

  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [tccw_pkg::CELL_W-1:0]   mem_wdata;
  logic                          mem_re;
  logic [ADDR_W-1:0]             mem_raddr;
  logic [tccw_pkg::CELL_W-1:0]   mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tab_width  <= tccw_pkg::TAB_WIDTH_RST;
      cfg_q.tab_attr   <= tccw_pkg::TAB_ATTR_RST;
      cfg_q.blank_attr <= tccw_pkg::BLANK_ATTR_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        tccw_pkg::CFG_TAB_WIDTH:  cfg_q.tab_width  <= cfg_i.data[tccw_pkg::TAB_WIDTH_W-1:0];
        tccw_pkg::CFG_TAB_ATTR:   cfg_q.tab_attr   <= cfg_i.data;
        tccw_pkg::CFG_BLANK_ATTR: cfg_q.blank_attr <= cfg_i.data;
        default: begin
          // unmapped index: drop the write
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  tccw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (cur_op),
    .cursor_o (cursor),
    .prev_o   (prev),
    .status_o (cur_status)
  );

  tccw_mem #(
    .DEPTH (CELLS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tccw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_i       (cfg_q),
    .cursor_i    (cursor),
    .prev_i      (prev),
    .status_i    (cur_status),
    .cur_op_o    (cur_op),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

/* test/text_console_cell_writer_checker.sv */
// Checker for the text console cell writer: tracks the screen and cursor, compares every result.
`timescale 1ns / 100ps
module text_console_cell_writer_checker #(
  parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tccw_in_if   item_i,
  tccw_out_if  result_i,
  tccw_cfg_if  cfg_i,
  output int   error_count_o,
  output int   pending_o
);

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [tccw_pkg::CURSOR_CELL_W-1:0] cursor_cell;
    logic                               screen_cleared;
    logic [tccw_pkg::CHAR_W-1:0]        read_char;
    logic [tccw_pkg::ATTR_W-1:0]        read_attr;
  } cursor_report_t;

  logic [tccw_pkg::CELL_W-1:0] screen_cells [CELLS];
  int unsigned                 cursor_pos;
  tccw_pkg::cfg_t              regs;
  cursor_report_t              expected_reports_q [$];
  int                          mismatches = 0;
  int                          reports_due = 0;

  assign error_count_o = mismatches;
  assign pending_o     = reports_due;

  function automatic logic [tccw_pkg::CHAR_W-1:0] char_at(int unsigned idx);
    return (idx < CELLS) ? screen_cells[idx][tccw_pkg::CHAR_W-1:0] : '0;
  endfunction

  function automatic void store_cell(int unsigned idx, logic [tccw_pkg::CHAR_W-1:0] ch,
                                     logic [tccw_pkg::ATTR_W-1:0] attr);
    if (idx < CELLS) screen_cells[idx] = {attr, ch};
  endfunction

  // Blank the whole screen and home the cursor once it has run off the end.
  function automatic logic wrap_if_full();
    if (cursor_pos < CELLS) return 1'b0;
    for (int i = 0; i < CELLS; i++) store_cell(i, tccw_pkg::CHAR_BLANK, regs.blank_attr);
    cursor_pos = 0;
    return 1'b1;
  endfunction

  function automatic cursor_report_t advance_console(
    input logic                             is_read,
    input logic [tccw_pkg::CHAR_W-1:0]      ch,
    input logic [tccw_pkg::COLOR_W-1:0]     fg,
    input logic [tccw_pkg::COLOR_W-1:0]     bg,
    input logic [tccw_pkg::READ_CELL_W-1:0] rc
  );
    cursor_report_t r;
    int unsigned    c;
    r = '0;
    if (is_read) begin
      if (rc < CELLS) begin
        r.read_char = screen_cells[rc][tccw_pkg::CHAR_W-1:0];
        r.read_attr = screen_cells[rc][tccw_pkg::CELL_W-1:tccw_pkg::CHAR_W];
      end
    end else begin
      case (ch)
        tccw_pkg::CHAR_NEWLINE: cursor_pos = cursor_pos - cursor_pos % COLUMNS + COLUMNS;
        tccw_pkg::CHAR_BACKSPACE: begin
          c = cursor_pos;
          if (c != 0) begin
            // walk back over blanks only when sitting at a row start
            if (c % COLUMNS == 0 && char_at(c - 1) == tccw_pkg::CHAR_BLANK) begin
              while (c > 0 && char_at(c - 1) == tccw_pkg::CHAR_BLANK) c--;
            end else if (char_at(c - 1) == tccw_pkg::CHAR_NUL) begin
              while (c > 0 && char_at(c - 1) == tccw_pkg::CHAR_NUL) c--;
            end else begin
              c--;
              store_cell(c, tccw_pkg::CHAR_BLANK, regs.blank_attr);
            end
            cursor_pos = c;
          end
        end
        tccw_pkg::CHAR_TAB: begin
          // the end check runs per tab cell, so a tab may clear and keep writing
          for (int i = 0; i < regs.tab_width; i++) begin
            store_cell(cursor_pos, tccw_pkg::CHAR_NUL, regs.tab_attr);
            cursor_pos++;
            if (wrap_if_full()) r.screen_cleared = 1'b1;
          end
        end
        default: begin
          store_cell(cursor_pos, ch, {bg, fg});
          cursor_pos++;
        end
      endcase
      if (wrap_if_full()) r.screen_cleared = 1'b1;
    end
    r.cursor_cell = cursor_pos[tccw_pkg::CURSOR_CELL_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    cursor_report_t want;
    if (!rst_ni) begin
      for (int i = 0; i < CELLS; i++) screen_cells[i] = '0;
      cursor_pos = 0;
      regs = '{tab_width: tccw_pkg::TAB_WIDTH_RST, tab_attr: tccw_pkg::TAB_ATTR_RST,
               blank_attr: tccw_pkg::BLANK_ATTR_RST};
      expected_reports_q.delete();
    end else begin
      // retire results before queuing new items: a result never belongs to this edge's item
      if (result_i.valid && result_i.ready) begin
        if (expected_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual cursor_cell %0d", $time,
                   result_i.cursor_cell);
          mismatches++;
        end else begin
          want = expected_reports_q.pop_front();
          check_field("cursor_cell", 32'(want.cursor_cell), 32'(result_i.cursor_cell));
          check_field("screen_cleared", 32'(want.screen_cleared),
                      32'(result_i.screen_cleared));
          check_field("read_char", 32'(want.read_char), 32'(result_i.read_char));
          check_field("read_attr", 32'(want.read_attr), 32'(result_i.read_attr));
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (tccw_pkg::cfg_reg_e'(cfg_i.index))
          tccw_pkg::CFG_TAB_WIDTH:  regs.tab_width  = cfg_i.data[tccw_pkg::TAB_WIDTH_W-1:0];
          tccw_pkg::CFG_TAB_ATTR:   regs.tab_attr   = cfg_i.data;
          tccw_pkg::CFG_BLANK_ATTR: regs.blank_attr = cfg_i.data;
          default: ;
        endcase
      end
      if (item_i.valid && item_i.ready)
        expected_reports_q.push_back(advance_console(item_i.kind, item_i.char_code,
                                                     item_i.fg_color, item_i.bg_color,
                                                     item_i.read_cell));
    end
    reports_due = expected_reports_q.size();
  end

endmodule

/* test/text_console_cell_writer_top_test.sv */
// Stimulus and verdict for the text console cell writer: directed cases, then random phases.
`timescale 1ns / 100ps
module text_console_cell_writer_top_test;

  localparam int   CELLS           = tccw_pkg::COLUMNS_DEF * tccw_pkg::ROWS_DEF;
  localparam int   PHASES          = 8;
  localparam int   ITEMS_PER_PHASE = 156;
  localparam int   QUIET_LIMIT     = 40000;
  localparam logic KIND_PUT        = 1'b0;
  localparam logic KIND_READ       = 1'b1;

  // per-phase register settings, phase 0 in the lowest slot
  localparam logic [PHASES*tccw_pkg::TAB_WIDTH_W-1:0] TAB_WIDTH_PLAN =
    {4'd5, 4'd1, 4'd8, 4'd3, 4'd15, 4'd0, 4'd8, 4'd1};
  localparam logic [PHASES*tccw_pkg::ATTR_W-1:0] TAB_ATTR_PLAN =
    {8'h3C, 8'h81, 8'hF0, 8'h0F, 8'hA5, 8'h5A, 8'hFF, 8'h00};
  localparam logic [PHASES*tccw_pkg::ATTR_W-1:0] BLANK_ATTR_PLAN =
    {8'h7E, 8'h00, 8'h01, 8'hFF, 8'h80, 8'h17, 8'h00, 8'hFF};

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   last_cursor;
  int   phase_items;
  int   mismatches;
  int   reports_due;

  tccw_in_if  in_ch ();
  tccw_out_if out_ch ();
  tccw_cfg_if cfg_ch ();

  text_console_cell_writer_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  text_console_cell_writer_checker console_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .item_i        (in_ch),
    .result_i      (out_ch),
    .cfg_i         (cfg_ch),
    .error_count_o (mismatches),
    .pending_o     (reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) last_cursor <= int'(out_ch.cursor_cell);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[text_console_cell_writer_top] ERROR");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer, valid left high.
  task automatic put_item(input logic kind, input logic [tccw_pkg::CHAR_W-1:0] ch,
                          input logic [tccw_pkg::COLOR_W-1:0] fg,
                          input logic [tccw_pkg::COLOR_W-1:0] bg,
                          input logic [tccw_pkg::READ_CELL_W-1:0] rc);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.char_code <= ch;
    in_ch.fg_color  <= fg;
    in_ch.bg_color  <= bg;
    in_ch.read_cell <= rc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    phase_items++;
  endtask

  task automatic put_char(input logic [tccw_pkg::CHAR_W-1:0] ch);
    put_item(KIND_PUT, ch, tccw_pkg::COLOR_W'($urandom_range(15)),
             tccw_pkg::COLOR_W'($urandom_range(15)),
             tccw_pkg::READ_CELL_W'($urandom_range(2047)));
  endtask

  task automatic read_at(input int rc);
    put_item(KIND_READ, tccw_pkg::CHAR_W'($urandom_range(255)),
             tccw_pkg::COLOR_W'($urandom_range(15)), tccw_pkg::COLOR_W'($urandom_range(15)),
             tccw_pkg::READ_CELL_W'(rc));
  endtask

  // Drop valid and hold until every result is back and the block has settled.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input tccw_pkg::cfg_reg_e idx,
                           input logic [tccw_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_registers(input int p);
    write_reg(tccw_pkg::CFG_TAB_WIDTH, tccw_pkg::CFG_DATA_W'(
              TAB_WIDTH_PLAN[p*tccw_pkg::TAB_WIDTH_W +: tccw_pkg::TAB_WIDTH_W]));
    write_reg(tccw_pkg::CFG_TAB_ATTR, TAB_ATTR_PLAN[p*tccw_pkg::ATTR_W +: tccw_pkg::ATTR_W]);
    write_reg(tccw_pkg::CFG_BLANK_ATTR,
              BLANK_ATTR_PLAN[p*tccw_pkg::ATTR_W +: tccw_pkg::ATTR_W]);
    cfg_ch.valid <= 1'b0;
  endtask

  // One burst of typing-like traffic: words, line ends, tabs, erasures, reads, or noise.
  task automatic random_chunk();
    int                          pick;
    int                          near;
    int                          glyph_pick;
    logic [tccw_pkg::CHAR_W-1:0] ch;
    pick = $urandom_range(99);
    if (pick < 35) begin
      repeat ($urandom_range(1, 12)) begin
        glyph_pick = $urandom_range(99);
        if (glyph_pick < 70)
          ch = tccw_pkg::CHAR_W'(97 + $urandom_range(25));
        else if (glyph_pick < 80)
          ch = ($urandom_range(1) != 0) ? tccw_pkg::CHAR_BLANK : tccw_pkg::CHAR_NUL;
        else
          ch = tccw_pkg::CHAR_W'($urandom_range(255));
        put_char(ch);
      end
    end else if (pick < 47) begin
      repeat ($urandom_range(1, 3)) put_char(tccw_pkg::CHAR_NEWLINE);
    end else if (pick < 51) begin
      // run toward the end of the screen to force clears
      repeat ($urandom_range(10, 25)) put_char(tccw_pkg::CHAR_NEWLINE);
    end else if (pick < 63) begin
      repeat ($urandom_range(1, 3)) put_char(tccw_pkg::CHAR_TAB);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 4)) put_char(tccw_pkg::CHAR_BACKSPACE);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(1) != 0) begin
          near = last_cursor - int'($urandom_range(20));
          read_at((near < 0) ? 0 : near);
        end else begin
          read_at(int'($urandom_range(2047)));
        end
      end
    end else begin
      put_item(1'($urandom_range(1)), tccw_pkg::CHAR_W'($urandom_range(255)),
               tccw_pkg::COLOR_W'($urandom_range(15)), tccw_pkg::COLOR_W'($urandom_range(15)),
               tccw_pkg::READ_CELL_W'($urandom_range(2047)));
    end
  endtask

  initial begin : stimulus
    rst_n           = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    last_cursor     = 0;
    phase_items     = 0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = KIND_PUT;
    in_ch.char_code = '0;
    in_ch.fg_color  = '0;
    in_ch.bg_color  = '0;
    in_ch.read_cell = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = tccw_pkg::CFG_TAB_WIDTH;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // newlines down past the last row clear the screen, so every cell is defined afterwards
    repeat (tccw_pkg::ROWS_DEF) put_char(tccw_pkg::CHAR_NEWLINE);

    put_char(tccw_pkg::CHAR_BACKSPACE);                     // at cell 0: no move
    put_item(KIND_PUT, 8'd65, 4'hF, 4'hF, '0);
    put_item(KIND_PUT, 8'hFF, 4'h0, 4'hF, '0);
    put_item(KIND_PUT, tccw_pkg::CHAR_NUL, 4'hF, 4'h0, 11'h7FF);
    put_item(KIND_PUT, tccw_pkg::CHAR_BLANK, 4'h5, 4'hA, '0);
    put_char(tccw_pkg::CHAR_BACKSPACE);                     // blanks the previous cell
    put_char(tccw_pkg::CHAR_BACKSPACE);                     // walks back over a NUL cell
    put_char(tccw_pkg::CHAR_TAB);
    read_at(3);
    put_char(tccw_pkg::CHAR_BACKSPACE);                     // walks back over the tab cells
    read_at(0);
    read_at(1);
    read_at(CELLS - 1);
    read_at(CELLS);                                         // out of range reads as zero
    read_at(32'h7FF);
    put_char(tccw_pkg::CHAR_NEWLINE);
    put_char(tccw_pkg::CHAR_BACKSPACE);                     // row start after blank: walk back
    put_char(tccw_pkg::CHAR_NEWLINE);
    put_char(tccw_pkg::CHAR_NEWLINE);
    put_char(tccw_pkg::CHAR_BACKSPACE);
    put_item(KIND_PUT, 8'd122, 4'h0, 4'h0, '0);
    read_at(6);
    finish_phase();

    for (int p = 0; p < PHASES; p++) begin
      program_registers(p);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_items = 0;
      while (phase_items < ITEMS_PER_PHASE) random_chunk();
      finish_phase();
    end

    repeat (50) @(posedge clk);
    if (mismatches == 0 && reports_due == 0)
      $display("[text_console_cell_writer_top] OK");
    else
      $display("[text_console_cell_writer_top] ERROR");
    $finish;
  end

endmodule
